FILE: src/vdl_pkg.sv
// vdl_pkg: shared types, constants and codes for the directional vertex lighting block
// used by every module in src
`default_nettype none

package vdl_pkg;

  localparam int LIGHT_SLOTS_DEF = 8;
  localparam int COLOR_W         = 8;
  localparam int VEC_W           = 16;
  localparam int PROD_W          = 2 * VEC_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int CONTRIB_W       = COLOR_W + PROD_W;
  localparam int FRAC_BITS       = 28;
  localparam int SLOT_FIELD_W    = 3;
  localparam int COUNT_W         = 3;
  localparam int SLOT_EXT_W      = 5;
  localparam int IN_DATA_W       = 80;
  localparam int OUT_DATA_W      = 24;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  localparam logic REG_LIGHT_COUNT = 1'b0;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] z;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t   dir;
    color_t col;
  } light_t;

  typedef struct packed {
    logic issue;
    logic last;
    logic clear;
  } vdl_ctrl_t;

endpackage

`default_nettype wire

FILE: src/vdl_light_mem.sv
// vdl_light_mem: light table, one synchronous memory of color and direction per slot
// depends on vdl_pkg
`default_nettype none

module vdl_light_mem #(
  parameter int LIGHT_SLOTS = vdl_pkg::LIGHT_SLOTS_DEF
) (
  input  wire                             clk_i,
  input  wire                             wr_en_i,
  input  wire [$clog2(LIGHT_SLOTS)-1:0]   wr_idx_i,
  input  vdl_pkg::light_t                 wr_data_i,
  input  wire                             rd_en_i,
  input  wire [$clog2(LIGHT_SLOTS)-1:0]   rd_idx_i,
  output vdl_pkg::light_t                 rd_data_o
);
  import vdl_pkg::*;

  light_t mem_q [LIGHT_SLOTS];
  light_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: src/vdl_datapath.sv
// vdl_datapath: dot product, diffuse scaling and per-channel accumulation pipeline
// depends on vdl_pkg, fed by vdl_light_mem read data
`default_nettype none

module vdl_datapath #(
  parameter int LIGHT_SLOTS = vdl_pkg::LIGHT_SLOTS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  vdl_pkg::vdl_ctrl_t ctrl_i,
  input  vdl_pkg::vec_t      normal_i,
  input  vdl_pkg::light_t    light_i,
  output logic               done_o,
  output vdl_pkg::color_t    result_o
);
  import vdl_pkg::*;

  localparam int ACC_W = CONTRIB_W + $clog2(LIGHT_SLOTS);
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(64'd255 << FRAC_BITS);

  vec_t norm_q;

  logic v1_q, last1_q, v2_q, last2_q, v3_q, last3_q, v4_q, last4_q;

  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  color_t                   col2_q, col3_q;
  logic signed [DOT_W-1:0]  dot_d, dot_q;
  logic [CONTRIB_W-1:0]     cr_d, cg_d, cb_d, cr_q, cg_q, cb_q;
  logic [ACC_W-1:0]         accr_q, accg_q, accb_q;
  logic                     dot_pos;

  function automatic logic [COLOR_W-1:0] clamp_ch(input logic [ACC_W-1:0] acc);
    logic [COLOR_W-1:0] res;
    if (acc > ACC_ONE) begin
      res = {COLOR_W{1'b1}};
    end else begin
      res = acc[FRAC_BITS +: COLOR_W];
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      v3_q    <= 1'b0;
      last3_q <= 1'b0;
      v4_q    <= 1'b0;
      last4_q <= 1'b0;
    end else begin
      v1_q    <= ctrl_i.issue;
      last1_q <= ctrl_i.issue & ctrl_i.last;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      v3_q    <= v2_q;
      last3_q <= last2_q;
      v4_q    <= v3_q;
      last4_q <= last3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      norm_q <= normal_i;
    end
  end

  // stage 2: component products
  always_ff @(posedge clk_i) begin
    px_q   <= light_i.dir.x * norm_q.x;
    py_q   <= light_i.dir.y * norm_q.y;
    pz_q   <= light_i.dir.z * norm_q.z;
    col2_q <= light_i.col;
  end

  // stage 3: dot product
  assign dot_d = DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q);

  always_ff @(posedge clk_i) begin
    dot_q  <= dot_d;
    col3_q <= col2_q;
  end

  // stage 4: contribution, ambient scaled by one, lights only when facing
  assign dot_pos = !dot_q[DOT_W-1] && (dot_q != '0);

  always_comb begin
    if (last3_q) begin
      cr_d = CONTRIB_W'(col3_q.red) << FRAC_BITS;
      cg_d = CONTRIB_W'(col3_q.green) << FRAC_BITS;
      cb_d = CONTRIB_W'(col3_q.blue) << FRAC_BITS;
    end else if (dot_pos) begin
      cr_d = CONTRIB_W'(col3_q.red) * CONTRIB_W'(dot_q[PROD_W-1:0]);
      cg_d = CONTRIB_W'(col3_q.green) * CONTRIB_W'(dot_q[PROD_W-1:0]);
      cb_d = CONTRIB_W'(col3_q.blue) * CONTRIB_W'(dot_q[PROD_W-1:0]);
    end else begin
      cr_d = '0;
      cg_d = '0;
      cb_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q <= cr_d;
    cg_q <= cg_d;
    cb_q <= cb_d;
  end

  // accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accr_q <= '0;
      accg_q <= '0;
      accb_q <= '0;
    end else if (ctrl_i.clear) begin
      accr_q <= '0;
      accg_q <= '0;
      accb_q <= '0;
    end else if (v4_q) begin
      accr_q <= accr_q + ACC_W'(cr_q);
      accg_q <= accg_q + ACC_W'(cg_q);
      accb_q <= accb_q + ACC_W'(cb_q);
    end
  end

  assign done_o         = v4_q & last4_q;
  assign result_o.red   = clamp_ch(accr_q);
  assign result_o.green = clamp_ch(accg_q);
  assign result_o.blue  = clamp_ch(accb_q);

endmodule

`default_nettype wire

FILE: src/vertex_directional_lighting.sv
// Directional vertex lighting: light table load and per-vertex diffuse shading.
// A vertex transaction with n active lights reads one table entry per light plus
// the ambient entry through a 4-stage pipeline; no new item is taken until its
// result enters the output register, which waits while an earlier result is unaccepted.
// Reset clears control and sets light_count to 0; the light table stays undefined
// until loaded. Depends on vdl_pkg, vdl_light_mem and vdl_datapath.
`default_nettype none

module vertex_directional_lighting #(
  parameter int LIGHT_SLOTS = vdl_pkg::LIGHT_SLOTS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // slot[2:0], color_red[10:3], color_green[18:11], color_blue[26:19],
  // vec_x[42:27], vec_y[58:43], vec_z[74:59], zero[79:75]
  input  wire [vdl_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // cmd[0]
  input  wire                                  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [vdl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [vdl_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire [vdl_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [vdl_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import vdl_pkg::*;

  localparam int IDX_W = $clog2(LIGHT_SLOTS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  logic [COUNT_W-1:0] light_count_q;
  logic               cfg_wr;

  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] n_q, n_d;

  logic [SLOT_FIELD_W-1:0] in_slot;
  light_t                  in_light;
  logic [SLOT_EXT_W-1:0]   slot_ext, cnt_ext, cnt_sat;
  logic                    in_acc, load_acc, vert_acc, slot_ok;

  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic                    out_load;

  vdl_ctrl_t ctrl;
  light_t    rd_data;
  logic      done;
  color_t    result;

  assign in_slot             = s_axis_tdata[2:0];
  assign in_light.col.red    = s_axis_tdata[10:3];
  assign in_light.col.green  = s_axis_tdata[18:11];
  assign in_light.col.blue   = s_axis_tdata[26:19];
  assign in_light.dir.x      = s_axis_tdata[42:27];
  assign in_light.dir.y      = s_axis_tdata[58:43];
  assign in_light.dir.z      = s_axis_tdata[74:59];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign load_acc      = in_acc & (s_axis_tuser == CMD_LOAD);
  assign vert_acc      = in_acc & (s_axis_tuser == CMD_VERTEX);

  assign slot_ext = SLOT_EXT_W'(in_slot);
  assign slot_ok  = (32'(in_slot) < LIGHT_SLOTS);

  // ambient slot index, saturated to the table
  assign cnt_ext = SLOT_EXT_W'(light_count_q);
  assign cnt_sat = (cnt_ext > SLOT_EXT_W'(LIGHT_SLOTS - 1)) ?
                   SLOT_EXT_W'(LIGHT_SLOTS - 1) : cnt_ext;
  assign n_d     = vert_acc ? cnt_sat[IDX_W-1:0] : n_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_LIGHT_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LIGHT_COUNT) begin
      prdata = APB_DATA_W'(light_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_count_q <= '0;
    end else if (cfg_wr) begin
      light_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (vert_acc) begin
          state_d  = ST_RUN;
          rd_idx_d = '0;
        end
      end
      ST_RUN: begin
        if (rd_idx_q == n_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      n_q      <= n_d;
    end
  end

  assign ctrl.issue = (state_q == ST_RUN);
  assign ctrl.last  = (rd_idx_q == n_q);
  assign ctrl.clear = vert_acc;

  vdl_light_mem #(
    .LIGHT_SLOTS(LIGHT_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc & slot_ok),
    .wr_idx_i  (slot_ext[IDX_W-1:0]),
    .wr_data_i (in_light),
    .rd_en_i   (ctrl.issue),
    .rd_idx_i  (rd_idx_q),
    .rd_data_o (rd_data)
  );

  vdl_datapath #(
    .LIGHT_SLOTS(LIGHT_SLOTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .normal_i (in_light.dir),
    .light_i  (rd_data),
    .done_o   (done),
    .result_o (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {result.blue, result.green, result.red};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: test/vdl_checker.sv
`timescale 1ns / 1ps
// vdl_checker: watches the stream and register ports of vertex_directional_lighting,
// keeps its own light table, predicts each lit vertex color and compares it
// with the output stream; depends on vdl_pkg
module vdl_checker
  import vdl_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  input  wire                   s_axis_tready,
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,
  input  wire                   s_axis_tuser,
  input  wire                   m_axis_tvalid,
  input  wire                   m_axis_tready,
  input  wire [OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  input  wire                   pready,
  output int                    fail_count,
  output int                    pending_count
);

  localparam longint SAT_LEVEL = longint'(255) <<< FRAC_BITS;
  localparam int     COL_LSB   = SLOT_FIELD_W;
  localparam int     DIR_LSB   = SLOT_FIELD_W + $bits(color_t);

  color_t             lamp_color [LIGHT_SLOTS_DEF];
  vec_t               lamp_dir   [LIGHT_SLOTS_DEF];
  logic [COUNT_W-1:0] active_lights;
  color_t             lit_colors [$];
  string              chan_name  [3] = '{"out_red", "out_green", "out_blue"};

  // ambient from the slot at active_lights, plus every light below active_lights facing the normal
  function automatic color_t light_vertex(vec_t nrm);
    longint acc [3];
    longint dot;
    color_t res;
    for (int k = 0; k < 3; k++)
      acc[k] = longint'(lamp_color[active_lights][8*k +: 8]) <<< FRAC_BITS;
    for (int l = 0; l < active_lights; l++) begin
      dot = longint'($signed(lamp_dir[l].x)) * longint'($signed(nrm.x))
          + longint'($signed(lamp_dir[l].y)) * longint'($signed(nrm.y))
          + longint'($signed(lamp_dir[l].z)) * longint'($signed(nrm.z));
      if (dot > 0) begin
        for (int k = 0; k < 3; k++)
          acc[k] += longint'(lamp_color[l][8*k +: 8]) * dot;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (acc[k] > SAT_LEVEL) acc[k] = SAT_LEVEL;
      if (acc[k] < 0) acc[k] = 0;
      res[8*k +: 8] = 8'(acc[k] >>> FRAC_BITS);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_t want;
    color_t got;
    int     errs;
    errs = 0;
    if (!rst_ni) begin
      active_lights <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_LIGHT_COUNT, 2'b00}) begin
        active_lights <= pwdata[COUNT_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_LOAD) begin
          lamp_color[s_axis_tdata[SLOT_FIELD_W-1:0]] <= s_axis_tdata[COL_LSB +: $bits(color_t)];
          lamp_dir[s_axis_tdata[SLOT_FIELD_W-1:0]]   <= s_axis_tdata[DIR_LSB +: $bits(vec_t)];
        end else begin
          lit_colors.push_back(light_vertex(s_axis_tdata[DIR_LSB +: $bits(vec_t)]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (lit_colors.size() == 0) begin
          $error("output transaction with no vertex pending: %h", got);
          errs++;
        end else begin
          want = lit_colors.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (got[8*k +: 8] !== want[8*k +: 8]) begin
              $error("%s: expected %0d, got %0d", chan_name[k], want[8*k +: 8], got[8*k +: 8]);
              errs++;
            end
          end
        end
      end
      fail_count    <= fail_count + errs;
      pending_count <= lit_colors.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// tb: top of the vertex_directional_lighting testbench; drives light loads, vertices,
// register writes and output stalls, and gives the verdict from vdl_checker
// depends on vdl_pkg, vertex_directional_lighting and vdl_checker
module tb;
  import vdl_pkg::*;

  localparam int STALL_PCT      = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_CYCLES   = 16;
  localparam int Q_ONE          = 16384;
  localparam int Q_MAX          = 32767;
  localparam int Q_MIN          = -32768;
  localparam int Q_DIAG         = 9459;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = CMD_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count   = 0;
  int                    idle_cycles   = 0;
  logic                  quiet;

  // stretches with no stalls on either side
  assign quiet = (cycle_count % 3000) >= 2200;

  vertex_directional_lighting dut (.*);

  vdl_checker shade_chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL vertex_directional_lighting");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_transaction(input logic cmd, input logic [SLOT_FIELD_W-1:0] slot,
                                  input color_t col, input vec_t v);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W - SLOT_FIELD_W - $bits(light_t)){1'b0}}, v, col, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_light(input int slot, input int r, input int g, input int b,
                            input int x, input int y, input int z);
    color_t c;
    vec_t   v;
    c.red   = COLOR_W'(r);
    c.green = COLOR_W'(g);
    c.blue  = COLOR_W'(b);
    v.x     = VEC_W'(x);
    v.y     = VEC_W'(y);
    v.z     = VEC_W'(z);
    send_transaction(CMD_LOAD, SLOT_FIELD_W'(slot), c, v);
  endtask

  task automatic shade(input int x, input int y, input int z);
    vec_t v;
    v.x = VEC_W'(x);
    v.y = VEC_W'(y);
    v.z = VEC_W'(z);
    send_transaction(CMD_VERTEX, '0, '0, v);
  endtask

  // wait for every lit vertex, then let the pipeline settle
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_light_count(input int n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LIGHT_COUNT, 2'b00};
    pwdata  <= APB_DATA_W'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    color_t      col;
    vec_t        vec;
    logic [63:0] raw;
    logic        cmd;
    int          pick;
    int          axis;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole table first so no vertex ever reads an unloaded slot
    load_light(0, 255, 255, 255, Q_ONE, 0, 0);
    load_light(1, 0, 0, 0, 0, Q_ONE, 0);
    load_light(2, 255, 128, 1, Q_MIN, Q_MIN, Q_MIN);
    load_light(3, 1, 2, 3, Q_MAX, Q_MAX, Q_MAX);
    load_light(4, 128, 64, 32, 0, 0, Q_ONE);
    load_light(5, 200, 100, 50, -Q_ONE, 0, 0);
    load_light(6, 17, 34, 51, Q_DIAG, Q_DIAG, Q_DIAG);
    load_light(7, 10, 20, 30, 0, 0, -Q_ONE);
    // light count zero after reset: ambient only
    shade(0, 0, Q_ONE);
    drain_block();

    write_light_count(7);
    shade(Q_ONE, 0, 0);
    shade(-Q_ONE, 0, 0);
    shade(Q_MIN, Q_MIN, Q_MIN);
    shade(Q_MAX, Q_MAX, Q_MAX);
    shade(0, 0, 0);
    shade(-Q_DIAG, Q_DIAG, -Q_DIAG);
    // dim light 0 and black ambient in slot 7
    load_light(0, 40, 40, 40, Q_ONE, 0, 0);
    load_light(7, 0, 0, 0, 0, 0, 0);
    shade(Q_DIAG, -Q_DIAG, Q_DIAG);
    shade(0, 0, -Q_ONE);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_block();
      write_light_count(ph == 0 ? 7 : ph == 1 ? 0 : $urandom_range(7));
      repeat (PHASE_ITEMS) begin
        cmd  = ($urandom_range(99) < 25) ? CMD_LOAD : CMD_VERTEX;
        col  = 24'($urandom);
        pick = $urandom_range(99);
        if (pick < 5) col = '1;
        else if (pick < 10) col = '0;
        pick = $urandom_range(99);
        if (pick < 70) begin
          // components bounded so the vector stays within unit length
          vec.x = VEC_W'($urandom_range(2 * Q_DIAG) - Q_DIAG);
          vec.y = VEC_W'($urandom_range(2 * Q_DIAG) - Q_DIAG);
          vec.z = VEC_W'($urandom_range(2 * Q_DIAG) - Q_DIAG);
        end else if (pick < 85) begin
          vec  = '0;
          axis = $urandom_range(2);
          vec[VEC_W*axis +: VEC_W] = $urandom_range(1) ? VEC_W'(Q_ONE) : VEC_W'(-Q_ONE);
        end else begin
          raw = {$urandom(), $urandom()};
          vec = raw[$bits(vec_t)-1:0];
        end
        send_transaction(cmd, SLOT_FIELD_W'($urandom), col, vec);
      end
    end
    drain_block();

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS vertex_directional_lighting");
    end else begin
      $display("FAIL vertex_directional_lighting");
    end
    $finish;
  end

endmodule
